### rtl/core/akf_pkg.sv
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types, codes and saturation helpers of the angle/speed Kalman filter.
// ----------------------------------------------------------------------------
package akf_pkg;

  localparam int unsigned WARMUP_ITEMS_DEF = 1;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 31;

  localparam logic [15:0] DT_RESET = 16'd655;
  localparam logic [30:0] QA_RESET = 31'd655;
  localparam logic [30:0] QS_RESET = 31'd655;
  localparam logic [30:0] R_RESET  = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP   = 2'd0,
    REG_NOISE_ANGLE = 2'd1,
    REG_NOISE_SPEED = 2'd2,
    REG_MEAS_NOISE  = 2'd3
  } reg_idx_t;

  // Multiply steps of one corrected item, in issue order
  typedef enum logic [3:0] {
    S_AP1 = 4'd0,  S_AP2 = 4'd1,  S_SP  = 4'd2,  S_N1  = 4'd3,
    S_N2  = 4'd4,  S_N3  = 4'd5,  S_N4  = 4'd6,  S_KA  = 4'd7,
    S_KS  = 4'd8,  S_P0  = 4'd9,  S_P1  = 4'd10, S_P2  = 4'd11,
    S_P3  = 4'd12
  } step_t;

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] acceleration;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] speed_estimate;
    logic               corrected;
  } out_item_t;

  typedef struct packed {
    logic  load;
    logic  mul_go;
    logic  post;
    step_t step;
    logic  div_go;
    logic  div_sel;
    logic  div_post;
    logic  gain_zero;
    logic  out_load;
    logic  corrected;
  } akf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic den_zero;
  } akf_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sd2147483647;
    lo = -44'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sd549755813887;
    lo = -44'sd549755813888;
    if (v > hi) return 40'sh7fffffffff;
    else if (v < lo) return 40'sh8000000000;
    else return v[39:0];
  endfunction

endpackage

### rtl/core/akf_mul.sv
// ----------------------------------------------------------------------------
// akf_mul
// Sequential Q24.16 multiplier: 40x16 digit per cycle, saturating result.
// ----------------------------------------------------------------------------
module akf_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [39:0] a,
  input  logic signed [39:0] b,
  output logic               done,
  output logic signed [39:0] res
);

  logic        busy_r, done_r;
  logic [1:0]  cnt_r;
  logic        neg_r;
  logic [39:0] ma_r;
  logic [47:0] mb_r;
  logic [79:0] prod_r;
  logic signed [39:0] res_r;
  logic [55:0] pp;
  logic        big, edge_min;
  logic signed [39:0] sat_val;

  assign pp       = ma_r * mb_r[47:32];
  assign big      = |prod_r[79:55];
  assign edge_min = (prod_r[79:55] == 25'd1) && (prod_r[54:16] == 39'd0);

  always_comb begin
    if (!neg_r) sat_val = big ? 40'sh7fffffffff : signed'(prod_r[55:16]);
    else if (big && !edge_min) sat_val = 40'sh8000000000;
    else sat_val = -signed'(prod_r[55:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd3;
      end else if (busy_r) begin
        if (cnt_r != 2'd0) begin
          cnt_r <= cnt_r - 2'd1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and product registers; magnitudes are zero-extended
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= a[39] ^ b[39];
      ma_r   <= a[39] ? 40'(-a) : 40'(a);
      mb_r   <= {8'd0, (b[39] ? 40'(-b) : 40'(b))};
      prod_r <= '0;
    end else if (busy_r && cnt_r != 2'd0) begin
      prod_r <= {prod_r[63:0], 16'd0} + 80'(pp);
      mb_r   <= {mb_r[31:0], 16'd0};
    end else if (busy_r) begin
      res_r  <= sat_val;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### rtl/core/akf_div.sv
// ----------------------------------------------------------------------------
// akf_div
// Restoring divider, one quotient bit per cycle, truncating, saturating.
// ----------------------------------------------------------------------------
module akf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [55:0] num,
  input  logic signed [41:0] den,
  output logic               done,
  output logic signed [39:0] quo
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic [55:0] q_r;
  logic [41:0] rem_r;
  logic [41:0] dm_r;
  logic signed [39:0] quo_r;
  logic [42:0] trial;
  logic        fits;
  logic        big, edge_min;
  logic signed [39:0] sat_val;

  assign trial    = {rem_r, q_r[55]};
  assign fits     = trial >= 43'(dm_r);
  assign big      = |q_r[55:39];
  assign edge_min = (q_r[55:39] == 17'd1) && (q_r[38:0] == 39'd0);

  always_comb begin
    if (!neg_r) sat_val = big ? 40'sh7fffffffff : signed'(q_r[39:0]);
    else if (big && !edge_min) sat_val = 40'sh8000000000;
    else sat_val = -signed'(q_r[39:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd56;
      end else if (busy_r) begin
        if (cnt_r != 6'd0) begin
          cnt_r <= cnt_r - 6'd1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[55] ^ den[41];
      q_r   <= num[55] ? 56'(-num) : 56'(num);
      dm_r  <= den[41] ? 42'(-den) : 42'(den);
      rem_r <= '0;
    end else if (busy_r && cnt_r != 6'd0) begin
      rem_r <= fits ? 42'(trial - 43'(dm_r)) : trial[41:0];
      q_r   <= {q_r[54:0], fits};
    end else if (busy_r) begin
      quo_r <= sat_val;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/core/akf_dp.sv
// ----------------------------------------------------------------------------
// akf_dp
// Datapath: configuration, committed state, working registers, shared units.
// ----------------------------------------------------------------------------
module akf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [akf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [akf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  akf_pkg::in_item_t                 in_data,
  input  akf_pkg::akf_cmd_t                 cmd,
  output akf_pkg::akf_sts_t                 sts,
  output akf_pkg::out_item_t                out_data
);

  logic [15:0] dt_r;
  logic [30:0] qa_r, qs_r, r_r;

  logic signed [31:0] z_r, acc_r, ang_r, spd_r, ap_r, sp_r, inno_r;
  logic signed [39:0] p_r [4];
  logic signed [39:0] n00_r, n01_r, n10_r, n11_r, k0_r, k1_r;
  logic [15:0]        dt2_r;
  logic [14:0]        hdt2_r;
  logic signed [43:0] t_r;
  akf_pkg::out_item_t out_r;

  logic [31:0]        dtsq;
  logic signed [39:0] mul_a, mul_b, m;
  logic               mul_done;
  logic signed [41:0] den;
  logic signed [55:0] num;
  logic signed [39:0] quo;
  logic               div_done;

  assign dtsq = dt_r * dt_r;

  always_comb begin
    unique case (cmd.step)
      akf_pkg::S_AP2:                                mul_a = 40'(hdt2_r);
      akf_pkg::S_N3:                                 mul_a = 40'(dt2_r);
      akf_pkg::S_KA, akf_pkg::S_P0, akf_pkg::S_P1:   mul_a = k0_r;
      akf_pkg::S_KS, akf_pkg::S_P2, akf_pkg::S_P3:   mul_a = k1_r;
      default:                                       mul_a = 40'(dt_r);
    endcase
    unique case (cmd.step)
      akf_pkg::S_AP1:                   mul_b = 40'(spd_r);
      akf_pkg::S_AP2, akf_pkg::S_SP:    mul_b = 40'(acc_r);
      akf_pkg::S_N1:                    mul_b = p_r[2];
      akf_pkg::S_N2:                    mul_b = p_r[1];
      akf_pkg::S_N3, akf_pkg::S_N4:     mul_b = p_r[3];
      akf_pkg::S_KA, akf_pkg::S_KS:     mul_b = 40'(inno_r);
      akf_pkg::S_P0, akf_pkg::S_P2:     mul_b = n00_r;
      default:                          mul_b = n01_r;
    endcase
  end

  akf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (m)
  );

  assign den = 42'(n00_r) + 42'(r_r);
  assign num = cmd.div_sel ? {n10_r, 16'd0} : {n00_r, 16'd0};

  akf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.den_zero = (den == 42'sd0);

  // configuration and committed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r  <= akf_pkg::DT_RESET;
      qa_r  <= akf_pkg::QA_RESET;
      qs_r  <= akf_pkg::QS_RESET;
      r_r   <= akf_pkg::R_RESET;
      ang_r <= '0;
      spd_r <= '0;
      for (int i = 0; i < 4; i++) p_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (akf_pkg::reg_idx_t'(cfg_index))
          akf_pkg::REG_TIME_STEP:   dt_r <= cfg_data[15:0];
          akf_pkg::REG_NOISE_ANGLE: qa_r <= cfg_data;
          akf_pkg::REG_NOISE_SPEED: qs_r <= cfg_data;
          akf_pkg::REG_MEAS_NOISE:  r_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.post) begin
        unique case (cmd.step)
          akf_pkg::S_KA: ang_r <= akf_pkg::sat32(44'(ap_r) + 44'(m));
          akf_pkg::S_KS: spd_r <= akf_pkg::sat32(44'(sp_r) + 44'(m));
          akf_pkg::S_P0: p_r[0] <= akf_pkg::sat40(44'(n00_r) - 44'(m));
          akf_pkg::S_P1: p_r[1] <= akf_pkg::sat40(44'(n01_r) - 44'(m));
          akf_pkg::S_P2: p_r[2] <= akf_pkg::sat40(44'(n10_r) - 44'(m));
          akf_pkg::S_P3: p_r[3] <= akf_pkg::sat40(44'(n11_r) - 44'(m));
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r    <= in_data.measured_angle;
      acc_r  <= in_data.acceleration;
      dt2_r  <= dtsq[31:16];
      hdt2_r <= dtsq[31:17];
    end
    if (cmd.post) begin
      unique case (cmd.step)
        akf_pkg::S_AP1: t_r <= 44'(ang_r) - 44'(m);
        akf_pkg::S_AP2: ap_r <= akf_pkg::sat32(t_r + 44'(m));
        akf_pkg::S_SP: begin
          sp_r   <= akf_pkg::sat32(44'(spd_r) + 44'(m));
          inno_r <= akf_pkg::sat32(44'(z_r) - 44'(ap_r));
        end
        akf_pkg::S_N1: t_r <= 44'(p_r[0]) - 44'(m);
        akf_pkg::S_N2: t_r <= t_r - 44'(m);
        akf_pkg::S_N3: begin
          n00_r <= akf_pkg::sat40(t_r + 44'(m) + 44'(qa_r));
          n11_r <= akf_pkg::sat40(44'(p_r[3]) + 44'(qs_r));
        end
        akf_pkg::S_N4: begin
          n01_r <= akf_pkg::sat40(44'(p_r[1]) - 44'(m));
          n10_r <= akf_pkg::sat40(44'(p_r[2]) - 44'(m));
        end
        default: ;
      endcase
    end
    if (cmd.gain_zero) begin
      k0_r <= '0;
      k1_r <= '0;
    end else if (cmd.div_post) begin
      if (cmd.div_sel) k1_r <= quo;
      else k0_r <= quo;
    end
    if (cmd.out_load) begin
      out_r.angle_estimate <= ang_r;
      out_r.speed_estimate <= spd_r;
      out_r.corrected      <= cmd.corrected;
    end
  end

  assign out_data = out_r;

endmodule

### rtl/core/akf_ctrl.sv
// ----------------------------------------------------------------------------
// akf_ctrl
// Sequencer: warm-up count, multiply/divide step order, output handshake.
// ----------------------------------------------------------------------------
module akf_ctrl #(
  parameter int unsigned WARMUP_ITEMS = akf_pkg::WARMUP_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  akf_pkg::akf_sts_t sts,
  output akf_pkg::akf_cmd_t cmd
);

  localparam int unsigned WCW = $clog2(WARMUP_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_MWAIT, ST_DGO, ST_DWAIT, ST_OUT
  } state_t;

  state_t          state_r, state_nxt;
  akf_pkg::step_t  step_r, step_nxt;
  logic            div_sel_r, div_sel_nxt;
  logic            corr_r, corr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [WCW-1:0]  warm_r, warm_nxt;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    div_sel_nxt = div_sel_r;
    corr_nxt    = corr_r;
    warm_nxt    = warm_r;
    cmd         = '0;
    cmd.step    = step_r;
    cmd.div_sel = div_sel_r;
    cmd.corrected = corr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (warm_r < WCW'(WARMUP_ITEMS)) begin
            warm_nxt  = warm_r + WCW'(1);
            corr_nxt  = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            corr_nxt  = 1'b1;
            step_nxt  = akf_pkg::S_AP1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (sts.mul_done) begin
          cmd.post = 1'b1;
          if (step_r == akf_pkg::S_N4) begin
            div_sel_nxt = 1'b0;
            state_nxt   = ST_DGO;
          end else if (step_r == akf_pkg::S_P3) begin
            state_nxt = ST_OUT;
          end else begin
            step_nxt  = akf_pkg::step_t'(step_r + 4'd1);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DGO: begin
        if (sts.den_zero) begin
          cmd.gain_zero = 1'b1;
          step_nxt      = akf_pkg::S_KA;
          state_nxt     = ST_MUL;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_post = 1'b1;
          if (!div_sel_r) begin
            div_sel_nxt = 1'b1;
            state_nxt   = ST_DGO;
          end else begin
            step_nxt  = akf_pkg::S_KA;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= akf_pkg::S_AP1;
      div_sel_r   <= 1'b0;
      corr_r      <= 1'b0;
      out_valid_r <= 1'b0;
      warm_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      div_sel_r   <= div_sel_nxt;
      corr_r      <= corr_nxt;
      out_valid_r <= out_valid_nxt;
      warm_r      <= warm_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_corr_after_warm: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.corrected) |-> (warm_r == WCW'(WARMUP_ITEMS)))
    else $error("corrected result during warm-up");

  a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> (state_r == ST_MWAIT))
    else $error("multiplier finished outside its wait state");

endmodule

### rtl/core/angle_speed_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_speed_kalman_filter
// Two-state (angle, angular speed) Kalman filter in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One item at a time. A warm-up item (the first WARMUP_ITEMS after reset)
// only bumps the warm-up count and returns the held estimate with corrected
// low; its result goes from the output state into the output register once
// that register is free. Every later item runs predict, gain and correction
// on one shared sequential multiplier (thirteen products, each written back
// when the multiplier is done) and one bit-serial divider (two gains).
// A zero denominator skips both divisions. The finished item sits in an
// output register, so the next item is taken while it waits to be read.
// Configuration writes take effect at once; write only while idle.
// ----------------------------------------------------------------------------
module angle_speed_kalman_filter #(
  parameter int unsigned WARMUP_ITEMS = akf_pkg::WARMUP_ITEMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  akf_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output akf_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [akf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [akf_pkg::CFG_DATA_W-1:0] cfg_data
);

  akf_pkg::akf_cmd_t cmd;
  akf_pkg::akf_sts_t sts;

  // sequencer: hold the step order and the output handshake
  akf_ctrl #(
    .WARMUP_ITEMS (WARMUP_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: state, covariance, shared multiplier and divider
  akf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
